/* hw/rtl/sip_pkg.sv */
package sip_pkg;

    localparam int CoordBits = 16;
    localparam int DiffBits  = CoordBits + 1;
    localparam int ProdBits  = 2 * CoordBits + 2;
    localparam int NumBits   = 2 * CoordBits + 3;
    localparam int RemBits   = NumBits;
    // front stages plus one cell per magnitude bit plus the output stage
    localparam int Latency   = 4 + DiffBits + 1;

    typedef struct packed {
        logic signed [CoordBits-1:0] a_start_x;
        logic signed [CoordBits-1:0] a_start_y;
        logic signed [CoordBits-1:0] a_end_x;
        logic signed [CoordBits-1:0] a_end_y;
        logic signed [CoordBits-1:0] b_start_x;
        logic signed [CoordBits-1:0] b_start_y;
        logic signed [CoordBits-1:0] b_end_x;
        logic signed [CoordBits-1:0] b_end_y;
    } t_sip_in;

    typedef struct packed {
        logic                        hit;
        logic signed [CoordBits-1:0] cross_x;
        logic signed [CoordBits-1:0] cross_y;
    } t_sip_out;

    // one division lane: remainder, quotient, scale magnitude and its sign
    typedef struct packed {
        logic [RemBits-1:0]  rem;
        logic [DiffBits-1:0] quo;
        logic [DiffBits-1:0] mag;
        logic                neg;
    } t_sip_lane;

    // data handed from cell to cell
    typedef struct packed {
        logic                        valid;
        logic                        hit;
        logic [NumBits-1:0]          num;
        logic [NumBits-1:0]          den;
        logic signed [CoordBits-1:0] x1;
        logic signed [CoordBits-1:0] y1;
        t_sip_lane                   lx;
        t_sip_lane                   ly;
    } t_sip_pipe;

endpackage

/* hw/rtl/sip_front.sv */
module sip_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  sip_pkg::t_sip_in   i_item,
    output sip_pkg::t_sip_pipe o_pipe
);

    localparam int DW = sip_pkg::DiffBits;
    localparam int PW = sip_pkg::ProdBits;
    localparam int NW = sip_pkg::NumBits;
    localparam int CW = sip_pkg::CoordBits;

    // stage A: differences
    logic                 r_va;
    logic signed [DW-1:0] r_dax, r_day, r_dbx, r_dby, r_ox, r_oy;
    logic signed [CW-1:0] r_xa, r_ya;
    // stage B: products
    logic                 r_vb;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [DW-1:0] r_daxb, r_dayb;
    logic signed [CW-1:0] r_xb, r_yb;
    // stage C: numerators and denominator
    logic                 r_vc;
    logic signed [NW-1:0] r_numa, r_numb, r_den;
    logic signed [DW-1:0] r_daxc, r_dayc;
    logic signed [CW-1:0] r_xc, r_yc;
    // stage D
    sip_pkg::t_sip_pipe   r_out, n_out;

    logic signed [NW-1:0] na, nb, dn;

    // hold valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_out.valid <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_out.valid <= n_out.valid;
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        r_dax <= DW'(i_item.a_end_x) - DW'(i_item.a_start_x);
        r_day <= DW'(i_item.a_end_y) - DW'(i_item.a_start_y);
        r_dbx <= DW'(i_item.b_end_x) - DW'(i_item.b_start_x);
        r_dby <= DW'(i_item.b_end_y) - DW'(i_item.b_start_y);
        r_ox  <= DW'(i_item.a_start_x) - DW'(i_item.b_start_x);
        r_oy  <= DW'(i_item.a_start_y) - DW'(i_item.b_start_y);
        r_xa  <= i_item.a_start_x;
        r_ya  <= i_item.a_start_y;

        r_p0   <= PW'(r_dbx) * PW'(r_oy);
        r_p1   <= PW'(r_dby) * PW'(r_ox);
        r_p2   <= PW'(r_dax) * PW'(r_oy);
        r_p3   <= PW'(r_day) * PW'(r_ox);
        r_p4   <= PW'(r_dby) * PW'(r_dax);
        r_p5   <= PW'(r_dbx) * PW'(r_day);
        r_daxb <= r_dax;
        r_dayb <= r_day;
        r_xb   <= r_xa;
        r_yb   <= r_ya;

        r_numa <= NW'(r_p0) - NW'(r_p1);
        r_numb <= NW'(r_p2) - NW'(r_p3);
        r_den  <= NW'(r_p4) - NW'(r_p5);
        r_daxc <= r_daxb;
        r_dayc <= r_dayb;
        r_xc   <= r_xb;
        r_yc   <= r_yb;

        r_out.hit <= n_out.hit;
        r_out.num <= n_out.num;
        r_out.den <= n_out.den;
        r_out.x1  <= n_out.x1;
        r_out.y1  <= n_out.y1;
        r_out.lx  <= n_out.lx;
        r_out.ly  <= n_out.ly;
    end

    // normalize the denominator sign and test both parameters
    always_comb begin
        na = r_den[NW-1] ? -r_numa : r_numa;
        nb = r_den[NW-1] ? -r_numb : r_numb;
        dn = r_den[NW-1] ? -r_den  : r_den;
        n_out.valid  = r_vc;
        n_out.hit    = (r_den != '0) && !na[NW-1] && !nb[NW-1] && (dn >= na) && (dn >= nb);
        n_out.num    = na;
        n_out.den    = dn;
        n_out.x1     = r_xc;
        n_out.y1     = r_yc;
        n_out.lx.rem = '0;
        n_out.lx.quo = '0;
        n_out.lx.mag = r_daxc[DW-1] ? -r_daxc : r_daxc;
        n_out.lx.neg = r_daxc[DW-1];
        n_out.ly.rem = '0;
        n_out.ly.quo = '0;
        n_out.ly.mag = r_dayc[DW-1] ? -r_dayc : r_dayc;
        n_out.ly.neg = r_dayc[DW-1];
    end

    assign o_pipe = r_out;

endmodule

/* hw/rtl/sip_cell.sv */
module sip_cell #(
    parameter int BIT_IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sip_pkg::t_sip_pipe i_pipe,
    output sip_pkg::t_sip_pipe o_pipe
);

    localparam int RW = sip_pkg::RemBits;

    sip_pkg::t_sip_pipe r_pipe, n_pipe;

    // one restoring step: double, reduce, add numerator on a set bit, reduce
    function automatic sip_pkg::t_sip_lane lane_step(sip_pkg::t_sip_lane l,
            logic [RW-1:0] num, logic [RW-1:0] den);
        sip_pkg::t_sip_lane o;
        o     = l;
        o.rem = {l.rem[RW-2:0], 1'b0};
        o.quo = {l.quo[sip_pkg::DiffBits-2:0], 1'b0};
        if (o.rem >= den) begin
            o.rem = o.rem - den;
            o.quo = o.quo + 1'b1;
        end
        if (l.mag[BIT_IDX]) begin
            o.rem = o.rem + num;
            if (o.rem >= den) begin
                o.rem = o.rem - den;
                o.quo = o.quo + 1'b1;
            end
        end
        return o;
    endfunction

    always_comb begin
        n_pipe    = i_pipe;
        n_pipe.lx = lane_step(i_pipe.lx, i_pipe.num, i_pipe.den);
        n_pipe.ly = lane_step(i_pipe.ly, i_pipe.num, i_pipe.den);
    end

    // hold valid, advance payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe.valid <= 1'b0;
        end else begin
            r_pipe.valid <= n_pipe.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pipe.hit <= n_pipe.hit;
        r_pipe.num <= n_pipe.num;
        r_pipe.den <= n_pipe.den;
        r_pipe.x1  <= n_pipe.x1;
        r_pipe.y1  <= n_pipe.y1;
        r_pipe.lx  <= n_pipe.lx;
        r_pipe.ly  <= n_pipe.ly;
    end

    assign o_pipe = r_pipe;

endmodule

/* hw/rtl/segment_intersection_point.sv */
// Segment intersection: one pair of segments enters per cycle on start (busy stays
// low) and its result leaves on o_valid for exactly one cycle; the receiver cannot
// stall. The latency is set by four front stages (differences, products, cross terms,
// sign test), one division cell for each of the 17 magnitude bits of the segment A
// extent, and the output register.
module segment_intersection_point (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  sip_pkg::t_sip_in  i_item,
    output logic              o_busy,
    output logic              o_valid,
    output sip_pkg::t_sip_out o_result
);

    localparam int DW = sip_pkg::DiffBits;
    localparam int CW = sip_pkg::CoordBits;

    sip_pkg::t_sip_pipe chain [DW+1];
    sip_pkg::t_sip_out  r_result, n_result;
    logic               r_valid;
    logic [CW-1:0]      qx, qy;

    assign o_busy = 1'b0;

    sip_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start),
        .i_item  (i_item),
        .o_pipe  (chain[0])
    );

    // one cell per magnitude bit, most significant first
    for (genvar g = 0; g < DW; g++) begin : g_cell
        sip_cell #(.BIT_IDX(DW - 1 - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pipe  (chain[g]),
            .o_pipe  (chain[g+1])
        );
    end

    // apply the sign and offset, zero the point on a miss
    always_comb begin
        qx = chain[DW].lx.neg ? -chain[DW].lx.quo[CW-1:0] : chain[DW].lx.quo[CW-1:0];
        qy = chain[DW].ly.neg ? -chain[DW].ly.quo[CW-1:0] : chain[DW].ly.quo[CW-1:0];
        n_result.hit     = chain[DW].hit;
        n_result.cross_x = chain[DW].hit ? chain[DW].x1 + qx : '0;
        n_result.cross_y = chain[DW].hit ? chain[DW].y1 + qy : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= chain[DW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // a miss always reports the origin
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.hit) |-> (o_result.cross_x == '0 && o_result.cross_y == '0))
        else $error("miss with nonzero point");

    // the output register follows the last cell
    a_out_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (chain[DW].valid && chain[DW].hit) |=> (o_valid && o_result.hit))
        else $error("hit lost at output");

endmodule

/* bench/sip_checker.sv */
`timescale 1ns / 1ps

module sip_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  sip_pkg::t_sip_in  i_item,
    input  logic              i_valid,
    input  sip_pkg::t_sip_out i_result,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_hit_count,
    output int                o_result_count
);

    sip_pkg::t_sip_out crossing_queue[$];

    // Truncated quotient of num * d / den, 0 <= num <= den, den > 0
    function automatic logic signed [sip_pkg::CoordBits-1:0] scaled_extent(
        input logic signed [127:0] num,
        input logic signed [127:0] den,
        input longint d
    );
        logic signed [127:0] prod;
        logic signed [127:0] quo;
        longint m;
        begin
            m = (d < 0) ? -d : d;
            prod = num * m;
            quo = prod / den;
            return (d < 0) ? -quo[sip_pkg::CoordBits-1:0] : quo[sip_pkg::CoordBits-1:0];
        end
    endfunction

    // Exact intersection test by sign and magnitude, then point on segment A
    function automatic sip_pkg::t_sip_out predict_crossing(input sip_pkg::t_sip_in it);
        sip_pkg::t_sip_out r;
        longint x1, y1, x2, y2, x3, y3, x4, y4;
        longint dax, day, dbx, dby, ox, oy;
        logic signed [127:0] numa, numb, den;
        begin
            r = '0;
            x1 = it.a_start_x; y1 = it.a_start_y;
            x2 = it.a_end_x;   y2 = it.a_end_y;
            x3 = it.b_start_x; y3 = it.b_start_y;
            x4 = it.b_end_x;   y4 = it.b_end_y;
            dax = x2 - x1; day = y2 - y1;
            dbx = x4 - x3; dby = y4 - y3;
            ox = x1 - x3;  oy = y1 - y3;
            numa = 128'(dbx * oy) - 128'(dby * ox);
            numb = 128'(dax * oy) - 128'(day * ox);
            den  = 128'(dby * dax) - 128'(dbx * day);
            if (den == 0)
                return r;
            if (den < 0) begin
                den = -den; numa = -numa; numb = -numb;
            end
            if (numa >= 0 && numb >= 0 && numa <= den && numb <= den) begin
                r.hit = 1'b1;
                r.cross_x = sip_pkg::CoordBits'(x1 + scaled_extent(numa, den, dax));
                r.cross_y = sip_pkg::CoordBits'(y1 + scaled_extent(numa, den, day));
            end
            return r;
        end
    endfunction

    assign o_pending = crossing_queue.size();

    // Predict on each input transfer, compare on each result transfer
    always @(posedge i_clk) begin
        sip_pkg::t_sip_out exp_r;
        if (!i_rst_n) begin
            crossing_queue.delete();
            o_fail_count <= 0;
            o_hit_count <= 0;
            o_result_count <= 0;
        end else begin
            if (i_valid) begin
                o_result_count <= o_result_count + 1;
                if (crossing_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result %p", i_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = crossing_queue.pop_front();
                    if (exp_r.hit)
                        o_hit_count <= o_hit_count + 1;
                    if (exp_r !== i_result) begin
                        if (o_fail_count < 10)
                            $display("result differs: expected %p actual %p", exp_r, i_result);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy)
                crossing_queue.push_back(predict_crossing(i_item));
        end
    end
endmodule

/* bench/tb_segment_intersection_point.sv */
`timescale 1ns / 1ps

module tb_segment_intersection_point;

    localparam int RandomItems = 2000;
    localparam int StallLimit  = 2000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    sip_pkg::t_sip_in   i_item;
    logic               o_busy;
    logic               o_valid;
    sip_pkg::t_sip_out  o_result;
    int                 fail_count;
    int                 pending;
    int                 hit_count;
    int                 result_count;
    int                 idle_cycles;
    int                 sent;

    segment_intersection_point dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    sip_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_item         (i_item),
        .i_valid        (o_valid),
        .i_result       (o_result),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_hit_count    (hit_count),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: count cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
            $display("segment_intersection_point: mismatch");
            $finish;
        end
    end

    // Hold one item on start until the transfer happens, maybe idle first
    task automatic send_pair(input sip_pkg::t_sip_in it, input bit may_idle);
        begin
            while (may_idle && $urandom_range(99) < 12) begin
                i_start <= 1'b0;
                @(negedge i_clk);
            end
            i_item <= it;
            i_start <= 1'b1;
            do @(posedge i_clk); while (o_busy);
            @(negedge i_clk);
        end
    endtask

    function automatic logic [15:0] pick_coord(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(64)) - 32);
            2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(4000)) - 2000);
        endcase
    endfunction

    // Mostly random pairs, some parallel, some sharing an endpoint
    function automatic sip_pkg::t_sip_in random_pair();
        sip_pkg::t_sip_in it;
        int mode;
        int shape;
        begin
            mode = $urandom_range(3);
            it.a_start_x = pick_coord(mode); it.a_start_y = pick_coord(mode);
            it.a_end_x   = pick_coord(mode); it.a_end_y   = pick_coord(mode);
            it.b_start_x = pick_coord(mode); it.b_start_y = pick_coord(mode);
            it.b_end_x   = pick_coord(mode); it.b_end_y   = pick_coord(mode);
            shape = $urandom_range(9);
            if (shape == 0) begin
                it.b_end_x = it.b_start_x + (it.a_end_x - it.a_start_x);
                it.b_end_y = it.b_start_y + (it.a_end_y - it.a_start_y);
            end else if (shape == 1) begin
                it.b_start_x = it.a_end_x;
                it.b_start_y = it.a_end_y;
            end
            return it;
        end
    endfunction

    function automatic sip_pkg::t_sip_in make_pair(input int x1, y1, x2, y2, x3, y3, x4, y4);
        sip_pkg::t_sip_in it;
        begin
            it.a_start_x = 16'(x1); it.a_start_y = 16'(y1);
            it.a_end_x   = 16'(x2); it.a_end_y   = 16'(y2);
            it.b_start_x = 16'(x3); it.b_start_y = 16'(y3);
            it.b_end_x   = 16'(x4); it.b_end_y   = 16'(y4);
            return it;
        end
    endfunction

    initial begin
        sip_pkg::t_sip_in it;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item  = '0;
        sent = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: crossing, parallel, collinear, endpoint touches, extremes
        send_pair(make_pair(0, 0, 160, 160, 0, 160, 160, 0), 1'b0);
        send_pair(make_pair(0, 0, 160, 0, 0, 16, 160, 16), 1'b0);
        send_pair(make_pair(0, 0, 160, 0, 32, 0, 320, 0), 1'b0);
        send_pair(make_pair(0, 0, 160, 0, 160, 0, 160, 160), 1'b0);
        send_pair(make_pair(0, 0, 160, 0, 0, -16, 0, 160), 1'b0);
        send_pair(make_pair(0, 0, 160, 0, 80, 1, 80, 160), 1'b0);
        send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768),
                  1'b0);
        send_pair(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767),
                  1'b0);
        send_pair(make_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767), 1'b0);
        send_pair(make_pair(5, 5, 5, 5, 0, 0, 10, 10), 1'b0);
        send_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1), 1'b0);
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        send_pair(make_pair(3, -7, -100, 33, -50, -50, 40, 60), 1'b0);

        // Hold off until the pipeline has drained
        i_start <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);

        // Random pairs; the first stretch runs back to back
        for (sent = 0; sent < RandomItems; sent++) begin
            it = random_pair();
            send_pair(it, sent >= 300);
        end

        i_start <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (sip_pkg::Latency + 4) @(negedge i_clk);

        $display("covered %0d results, %0d of them hits, directed cases and %0d random pairs",
                 result_count, hit_count, RandomItems);
        if (fail_count == 0 && pending == 0)
            $display("segment_intersection_point: match");
        else
            $display("segment_intersection_point: mismatch");
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/sip_pkg.sv
hw/rtl/sip_front.sv
hw/rtl/sip_cell.sv
hw/rtl/segment_intersection_point.sv
bench/sip_checker.sv
bench/tb_segment_intersection_point.sv
